>>> rtl/core/lzbd_pkg.sv
// Shared types and constants for the LZ bit-stream decompressor.
// No dependencies.
package lzbd_pkg;

    localparam int unsigned LIT_TOKEN_BITS = 9;
    localparam int unsigned COPY_BIAS      = 2;

    // register index of output_length on the config port (paddr[2])
    localparam logic REG_OUTPUT_LENGTH = 1'b0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       done;
    } t_emit;

endpackage

>>> rtl/core/lz_bitstream_decompressor.sv
// Top level of the LZ bit-stream decompressor: token parser, copy sequencer,
// config register. Depends on lzbd_pkg, lzbd_window, lzbd_outq.
//
//  channel   | valid        | stall        | beat
//  ----------+--------------+--------------+-----------------------------------------
//  input     | i_in_valid   | o_in_stall   | i_comp_byte, i_start_of_stream
//  output    | o_out_valid  | i_out_stall  | o_out_byte, o_last_of_run, o_stream_done
//  config    | psel/penable | pready (=1)  | paddr, pwrite, pwdata, prdata
//
// An input byte is accepted, then each literal is emitted, each copy token
// is decoded and its bytes read from the window one by one, and a closing
// token check returns the parser to idle. The window memory does one read
// and one write per cycle, which sets the copy rate.
// Reset (sync, active low) and start_of_stream need no clearing pass.
// A stalled output holds the parser only once the hold slot is also full.
module lz_bitstream_decompressor #(
    parameter int unsigned WINDOW_BITS = 12,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_comp_byte,
    input  logic        i_start_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_stream_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned TOK_BITS = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int unsigned ACC_W    = TOK_BITS - 1 + 8;
    localparam int unsigned N_W      = $clog2(ACC_W + 1);
    localparam int unsigned CNT_W    = LENGTH_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PARSE = 3'b010,
        ST_COPY  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [N_W-1:0]         r_n, n_n;
    logic [31:0]            r_bytes, n_bytes;
    logic                   r_fin, n_fin;
    logic [31:0]            r_len;
    logic [WINDOW_BITS-1:0] r_src, n_src;
    logic [CNT_W-1:0]       r_cnt, n_cnt;

    lzbd_pkg::t_emit        emit;
    logic                   emit_ok;
    logic                   mark_last;
    logic                   win_clear;
    logic                   rd_en;
    logic [WINDOW_BITS-1:0] rd_addr;
    logic [7:0]             rd_data;

    logic                   cfg_wr;
    logic [ACC_W-1:0]       pend_mask;
    logic [ACC_W-1:0]       pend;
    logic [N_W-1:0]         pend_n;
    logic [ACC_W-1:0]       load_acc;
    logic [ACC_W-1:0]       flag_sh;
    logic [ACC_W-1:0]       lit_sh;
    logic [ACC_W-1:0]       cpy_sh;
    logic [N_W-1:0]         lit_rem;
    logic [N_W-1:0]         cpy_rem;
    logic                   enough_lit;
    logic                   enough_cpy;
    logic [WINDOW_BITS-1:0] tok_src;
    logic [LENGTH_BITS-1:0] tok_cnt;
    logic                   len_hit;
    logic [31:0]            bytes_inc;
    logic                   inc_done;
    logic                   inc_hit;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lzbd_pkg::REG_OUTPUT_LENGTH);
    assign prdata = (paddr[2] == lzbd_pkg::REG_OUTPUT_LENGTH) ? r_len : 32'h0;

    assign o_in_stall = (r_state != ST_IDLE);

    // bit buffer
    assign pend_mask = (ACC_W'(1) << r_n) - ACC_W'(1);
    assign pend      = i_start_of_stream ? '0 : (r_acc & pend_mask);
    assign pend_n    = i_start_of_stream ? '0 : r_n;
    assign load_acc  = (pend << 8) | ACC_W'(i_comp_byte);

    assign flag_sh    = r_acc >> (r_n - N_W'(1));
    assign lit_rem    = r_n - N_W'(lzbd_pkg::LIT_TOKEN_BITS);
    assign cpy_rem    = r_n - N_W'(TOK_BITS);
    assign enough_lit = (r_n >= N_W'(lzbd_pkg::LIT_TOKEN_BITS));
    assign enough_cpy = (r_n >= N_W'(TOK_BITS));
    assign lit_sh     = r_acc >> lit_rem;
    assign cpy_sh     = r_acc >> cpy_rem;
    assign tok_cnt    = cpy_sh[LENGTH_BITS-1:0];
    assign tok_src    = cpy_sh[LENGTH_BITS +: WINDOW_BITS];

    assign len_hit   = (r_bytes >= r_len);
    assign bytes_inc = r_bytes + 32'd1;
    assign inc_done  = (bytes_inc == r_len);
    assign inc_hit   = (bytes_inc >= r_len);

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_n       = r_n;
        n_bytes   = r_bytes;
        n_fin     = r_fin;
        n_src     = r_src;
        n_cnt     = r_cnt;
        emit      = '0;
        mark_last = 1'b0;
        win_clear = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_src;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_start_of_stream) begin
                        n_bytes   = '0;
                        n_fin     = 1'b0;
                        win_clear = 1'b1;
                    end
                    if (i_start_of_stream || !r_fin) begin
                        n_acc   = load_acc;
                        n_n     = pend_n + N_W'(8);
                        n_state = ST_PARSE;
                    end
                end
            end
            ST_PARSE: begin
                if (r_n == '0) begin
                    mark_last = 1'b1;
                    n_state   = ST_IDLE;
                end else if (len_hit) begin
                    n_fin     = 1'b1;
                    n_acc     = '0;
                    n_n       = '0;
                    mark_last = 1'b1;
                    n_state   = ST_IDLE;
                end else if (flag_sh[0]) begin
                    if (!enough_lit) begin
                        mark_last = 1'b1;
                        n_state   = ST_IDLE;
                    end else if (emit_ok) begin
                        emit.valid = 1'b1;
                        emit.data  = lit_sh[7:0];
                        emit.done  = inc_done;
                        n_bytes    = bytes_inc;
                        n_n        = lit_rem;
                    end
                end else begin
                    if (!enough_cpy) begin
                        mark_last = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = tok_src;
                        n_src   = tok_src + WINDOW_BITS'(1);
                        n_cnt   = CNT_W'(tok_cnt) + CNT_W'(lzbd_pkg::COPY_BIAS);
                        n_n     = cpy_rem;
                        n_state = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                if (emit_ok) begin
                    emit.valid = 1'b1;
                    emit.data  = rd_data;
                    emit.done  = inc_done;
                    n_bytes    = bytes_inc;
                    if ((r_cnt == CNT_W'(1)) || inc_hit) begin
                        n_state = ST_PARSE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_src;
                        n_src   = r_src + WINDOW_BITS'(1);
                        n_cnt   = r_cnt - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_n     <= '0;
            r_bytes <= '0;
            r_fin   <= 1'b0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_n     <= n_n;
            r_bytes <= n_bytes;
            r_fin   <= n_fin;
            if (cfg_wr) begin
                r_len <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_cnt <= n_cnt;
    end

    lzbd_window #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (win_clear),
        .i_wr     (emit),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    lzbd_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (emit),
        .i_mark_last  (mark_last),
        .o_emit_ok    (emit_ok),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_stream_done(o_stream_done)
    );

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> emit_ok)
        else $error("beat emitted with no room in output stage");

    a_copy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_cnt != '0))
        else $error("copy running with zero count");

    a_fin_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !emit.valid)
        else $error("beat emitted after stream finished");

    a_fin_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && r_fin && !i_start_of_stream)
        |=> (r_state == ST_IDLE))
        else $error("finished stream parsed a byte");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_bytes < r_len))
        else $error("copy ran past output length");

endmodule

>>> rtl/core/lzbd_window.sv
// History window: single-port-write, single-read synchronous byte memory
// with write-to-read forwarding and fill tracking. Depends on lzbd_pkg.
module lzbd_window #(
    parameter int unsigned WINDOW_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  lzbd_pkg::t_emit        i_wr,
    input  logic                   i_rd_en,
    input  logic [WINDOW_BITS-1:0] i_rd_addr,
    output logic [7:0]             o_rd_data
);

    localparam int unsigned DEPTH = 1 << WINDOW_BITS;

    logic [7:0]             mem [0:DEPTH-1];
    logic [7:0]             r_q;
    logic                   r_fwd;
    logic [7:0]             r_fwd_data;
    logic                   r_zero;
    logic [WINDOW_BITS-1:0] r_wp;
    logic                   r_wrap;
    logic                   hit;
    logic                   written;

    assign hit     = i_wr.valid && (i_rd_addr == r_wp);
    // entries are written in order from position 1, so the write pointer
    // and a wrap flag tell which ones hold data since stream start
    assign written = r_wrap
                  || ((i_rd_addr != '0) && ((r_wp == '0) || (i_rd_addr < r_wp)))
                  || hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            mem[r_wp] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= mem[i_rd_addr];
            r_fwd      <= hit;
            r_fwd_data <= i_wr.data;
            r_zero     <= !written;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp   <= WINDOW_BITS'(1);
            r_wrap <= 1'b0;
        end else if (i_wr.valid) begin
            r_wp <= r_wp + WINDOW_BITS'(1);
            if (r_wp == '0) begin
                r_wrap <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_zero ? 8'h00 : (r_fwd ? r_fwd_data : r_q);

endmodule

>>> rtl/core/lzbd_outq.sv
// Output staging: one hold slot that waits to learn whether its beat is the
// last of its run, then the output register. Depends on lzbd_pkg.
module lzbd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lzbd_pkg::t_emit i_emit,
    input  logic            i_mark_last,
    output logic            o_emit_ok,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_stream_done
);

    logic       r_hv;
    logic       r_hlast;
    logic [7:0] r_hdata;
    logic       r_hdone;
    logic       r_ov;
    logic [7:0] r_odata;
    logic       r_olast;
    logic       r_odone;
    logic       out_free;
    logic       move;

    assign out_free  = !r_ov || !i_out_stall;
    assign move      = r_hv && out_free && (r_hlast || i_emit.valid);
    assign o_emit_ok = !r_hv || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= 1'b0;
            r_hlast <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_emit.valid) begin
                r_hv    <= 1'b1;
                r_hlast <= 1'b0;
            end else if (move) begin
                r_hv <= 1'b0;
            end else if (i_mark_last && r_hv) begin
                r_hlast <= 1'b1;
            end
            if (move) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_hdata <= i_emit.data;
            r_hdone <= i_emit.done;
        end
        if (move) begin
            r_odata <= r_hdata;
            r_odone <= r_hdone;
            r_olast <= r_hlast;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_odata;
    assign o_last_of_run = r_olast;
    assign o_stream_done = r_odone;

endmodule
